### rtl/nrwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrwc_pkg
// shared constants, codes and types of the nonce replay window check
// ----------------------------------------------------------------------------
package nrwc_pkg;

    localparam int NONCE_BYTES  = 6;
    localparam int NONCE_W      = 8 * NONCE_BYTES;
    localparam int WIN_SIZE     = 64;
    localparam int WIN_IW       = $clog2(WIN_SIZE);
    localparam int NOW_W        = 63;
    localparam int RT_W         = 32;
    localparam int DEADLINE_W   = 64;
    localparam int CFG_IW       = 1;
    localparam int CFG_DW       = 32;

    localparam logic [RT_W-1:0] REORDER_TIME_RST = RT_W'(10000);

    typedef enum logic [1:0] {
        VERDICT_REJECT  = 2'd0,
        VERDICT_ACCEPT  = 2'd1,
        VERDICT_REORDER = 2'd2,
        VERDICT_DUP     = 2'd3
    } t_verdict;

    typedef enum logic [CFG_IW-1:0] {
        CFG_INITIATOR_MODE = 1'd0,
        CFG_REORDER_TIME   = 1'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [NONCE_W-1:0]    newest;
        logic [WIN_SIZE-1:0]   bitmap;
        logic [DEADLINE_W-1:0] deadline;
    } t_win_state;

endpackage
`default_nettype wire

### rtl/nrwc_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrwc_eval
// verdict, age and next window state for one registered item
// ----------------------------------------------------------------------------
module nrwc_eval
    import nrwc_pkg::*;
(
    input  wire t_win_state         i_state,
    input  wire logic [NONCE_W-1:0] i_rx_nonce,
    input  wire logic [NOW_W-1:0]   i_now,
    input  wire logic               i_auth_ok,
    input  wire logic [RT_W-1:0]    i_reorder_time,
    output t_verdict                o_verdict,
    output logic [NONCE_W-1:0]      o_age,
    output t_win_state              o_state
);

    logic [NONCE_W:0]       diff;
    logic                   newer;
    logic [NONCE_W-1:0]     age;
    logic [NONCE_W-1:0]     mag;
    logic [NONCE_W-1:0]     mag_m1;
    logic [WIN_IW-1:0]      idx;
    logic                   parity_ok;
    logic                   mag_ge_win;
    logic                   mag_le_win;
    logic                   mag_zero;
    logic                   expired;
    logic [WIN_SIZE-1:0]    shifted;
    logic [WIN_SIZE-1:0]    bit_sel;
    logic [DEADLINE_W-1:0]  now_ext;

    // diff is even when parities match, so the age is the upper bits
    assign diff       = {1'b0, i_state.newest} - {1'b0, i_rx_nonce};
    assign newer      = diff[NONCE_W];
    assign age        = diff[NONCE_W:1];
    assign mag        = newer ? (NONCE_W'(0) - age) : age;
    assign mag_m1     = mag - NONCE_W'(1);
    assign idx        = mag_m1[WIN_IW-1:0];
    assign parity_ok  = (i_rx_nonce[0] == i_state.newest[0]);
    assign mag_ge_win = (mag >= NONCE_W'(WIN_SIZE));
    assign mag_le_win = (mag <= NONCE_W'(WIN_SIZE));
    assign mag_zero   = (mag == '0);
    assign now_ext    = DEADLINE_W'(i_now);
    assign expired    = (i_state.deadline <= now_ext);
    assign shifted    = mag_ge_win ? '0 : (i_state.bitmap << mag[WIN_IW-1:0]);
    assign bit_sel    = WIN_SIZE'(1) << idx;

    always_comb begin
        o_state   = i_state;
        o_verdict = VERDICT_REJECT;
        o_age     = age;
        if (!parity_ok) begin
            o_age = '0;
        end else if (newer) begin
            o_verdict = VERDICT_ACCEPT;
            if (i_auth_ok) begin
                o_state.bitmap   = shifted | (mag_le_win ? bit_sel : '0);
                o_state.newest   = i_rx_nonce;
                o_state.deadline = now_ext + DEADLINE_W'(i_reorder_time);
            end
        end else if (expired || (mag > NONCE_W'(WIN_SIZE))) begin
            o_verdict = VERDICT_REJECT;
        end else if (mag_zero || i_state.bitmap[idx]) begin
            o_verdict = VERDICT_DUP;
        end else begin
            o_verdict = VERDICT_REORDER;
            if (i_auth_ok) begin
                o_state.bitmap = i_state.bitmap | bit_sel;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/nonce_replay_window_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nonce_replay_window_check
// anti-replay sliding window check on received packet nonces
// ----------------------------------------------------------------------------
// One item is one received packet (nonce, current time, auth flag) and gives
// one result (verdict, signed age). An item is taken into an input register,
// judged there against the newest nonce, the 64-entry seen bitmap and the
// reorder deadline, and its result lands in an output register when the item
// advances, where the window state is also updated. A new item is accepted
// every cycle while the result side does not stall, and the output register
// lets the next item be taken while a result still waits.
// The combinational state update (one 49-bit subtract, a 64-bit shift and
// one bit test) sets the rate. Any write to the initiator mode register
// restarts the session; registers must only be written while no item is in
// flight.
// ----------------------------------------------------------------------------
module nonce_replay_window_check
    import nrwc_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration write port
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IW-1:0]         i_cfg_index,
    input  wire logic [CFG_DW-1:0]         i_cfg_data,
    // input item channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [NONCE_W-1:0]        i_rx_nonce,
    input  wire logic [NOW_W-1:0]          i_now,
    input  wire logic                      i_auth_ok,
    // result item channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [1:0]                     o_verdict,
    output logic signed [NONCE_W-1:0]      o_age
);

    // configuration registers
    logic [RT_W-1:0]        r_reorder_time;

    // window state
    t_win_state             r_state;
    t_win_state             n_state;
    t_win_state             eval_state;

    // input register
    logic                   r_in_valid;
    logic                   n_in_valid;
    logic [NONCE_W-1:0]     r_rx_nonce;
    logic [NOW_W-1:0]       r_now;
    logic                   r_auth_ok;

    // output register
    logic                   r_out_valid;
    logic                   n_out_valid;
    t_verdict               r_verdict;
    logic [NONCE_W-1:0]     r_age;
    t_verdict               eval_verdict;
    logic [NONCE_W-1:0]     eval_age;

    logic                   advance;    // item moves from input to output reg
    logic                   take;       // new item accepted
    logic                   restart;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign take       = i_in_valid && o_in_ready;
    assign restart    = i_cfg_we && (t_cfg_reg'(i_cfg_index) == CFG_INITIATOR_MODE);

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;
    assign o_age       = r_age;

    nrwc_eval u_eval (
        .i_state        (r_state),
        .i_rx_nonce     (r_rx_nonce),
        .i_now          (r_now),
        .i_auth_ok      (r_auth_ok),
        .i_reorder_time (r_reorder_time),
        .o_verdict      (eval_verdict),
        .o_age          (eval_age),
        .o_state        (eval_state)
    );

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        n_state     = r_state;
        if (take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        if (advance) begin
            n_out_valid = 1'b1;
            n_state     = eval_state;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        // session restart: responder starts from nonce 1, initiator from 0
        if (restart) begin
            n_state.newest   = {{(NONCE_W-1){1'b0}}, ~i_cfg_data[0]};
            n_state.bitmap   = '0;
            n_state.deadline = '0;
        end
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reorder_time  <= REORDER_TIME_RST;
            r_state.newest  <= NONCE_W'(1);
            r_state.bitmap  <= '0;
            r_state.deadline <= '0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_state     <= n_state;
            // initiator mode only matters at restart, where it comes from the write data
            if (i_cfg_we && (t_cfg_reg'(i_cfg_index) == CFG_REORDER_TIME)) begin
                r_reorder_time <= i_cfg_data[RT_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rx_nonce <= i_rx_nonce;
            r_now      <= i_now;
            r_auth_ok  <= i_auth_ok;
        end
        if (advance) begin
            r_verdict <= eval_verdict;
            r_age     <= eval_age;
        end
    end

endmodule
`default_nettype wire

### rtl/nrwc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrwc_checker
// port-level checks of the nonce replay window check
// ----------------------------------------------------------------------------
module nrwc_checker
    import nrwc_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_ready,
    input wire logic [1:0]               o_verdict,
    input wire logic signed [NONCE_W-1:0] o_age
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_verdict) && $stable(o_age))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // in-order accept only for a newer nonce
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_verdict == VERDICT_ACCEPT) |-> o_age[NONCE_W-1])
        else $error("in-order accept with non-negative age");

    // reordered accept lies strictly inside the window
    a_reorder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_verdict == VERDICT_REORDER) |->
            !o_age[NONCE_W-1] && (o_age != '0) && (o_age <= NONCE_W'(WIN_SIZE)))
        else $error("reordered accept outside window");

    // duplicate is the newest nonce or inside the window
    a_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_verdict == VERDICT_DUP) |->
            !o_age[NONCE_W-1] && (o_age <= NONCE_W'(WIN_SIZE)))
        else $error("duplicate outside window");

endmodule

bind nonce_replay_window_check nrwc_checker u_nrwc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_verdict   (o_verdict),
    .o_age       (o_age)
);
`default_nettype wire

### tb/nonce_replay_window_check_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nonce_replay_window_check_tb
// self-checking bench for the nonce replay window check
// ----------------------------------------------------------------------------
// A short stimulus table walks the corner cases first: parity mismatch,
// passed deadline, auth failure, a jump of exactly the window size, too old,
// reordered then duplicate, and the extremes of nonce, time and reorder time.
// Several random phases follow, each under its own register setting, with
// packets mostly placed around the newest nonce so the window logic is
// exercised, plus parity noise and far jumps. A local window model predicts
// every untyped result; results are compared in order as they leave the block.
// ----------------------------------------------------------------------------
module nonce_replay_window_check_tb;
    import nrwc_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int PHASE_PACKETS  = 100;
    localparam int PHASE_COUNT    = 7;

    localparam logic [NONCE_W-1:0] AGE_MINUS_ONE = {NONCE_W{1'b1}};
    localparam logic [NOW_W-1:0]   NOW_MAX       = {NOW_W{1'b1}};

    typedef enum logic {
        ROW_PACKET,
        ROW_REG_WRITE
    } t_row_kind;

    // one line of the directed table: a packet or a register write
    typedef struct packed {
        t_row_kind           kind;
        t_cfg_reg            reg_index;
        logic [CFG_DW-1:0]   reg_data;
        logic [NONCE_W-1:0]  nonce;
        logic [NOW_W-1:0]    stamp;
        logic                ok;
        logic                typed;
        t_verdict            verdict;
        logic [NONCE_W-1:0]  age;
    } t_stim_row;

    typedef struct packed {
        t_verdict            verdict;
        logic [NONCE_W-1:0]  age;
    } t_judgement;

    // clock, reset and block inputs, all known from time zero
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IW-1:0]    cfg_index   = '0;
    logic [CFG_DW-1:0]    cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic [NONCE_W-1:0]   rx_nonce    = '0;
    logic [NOW_W-1:0]     now_stamp   = '0;
    logic                 auth_ok     = 1'b0;
    logic                 out_ready   = 1'b0;

    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [1:0]           o_verdict;
    logic signed [NONCE_W-1:0] o_age;

    // window model state and its copy of the registers
    logic                   cfg_initiator;
    logic [RT_W-1:0]        cfg_reorder_time;
    logic [NONCE_W-1:0]     win_newest;
    logic [WIN_SIZE-1:0]    win_seen;
    logic [DEADLINE_W-1:0]  win_deadline;

    t_judgement  pending_verdicts[$];
    t_stim_row   corner_rows[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          ready_hold     = 0;
    logic        in_burst       = 1'b0;

    nonce_replay_window_check dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_nonce   (rx_nonce),
        .i_now        (now_stamp),
        .i_auth_ok    (auth_ok),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_verdict    (o_verdict),
        .o_age        (o_age)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    // session restart, as done by reset and any initiator mode write
    task automatic restart_window();
        win_newest   = cfg_initiator ? NONCE_W'(0) : NONCE_W'(1);
        win_seen     = '0;
        win_deadline = '0;
    endtask

    task automatic apply_reg(input t_cfg_reg idx, input logic [CFG_DW-1:0] data);
        if (idx == CFG_INITIATOR_MODE) begin
            cfg_initiator = data[0];
            restart_window();
        end else begin
            cfg_reorder_time = data[RT_W-1:0];
        end
    endtask

    // judge one packet against the window and update it when authenticated
    task automatic judge_packet(input logic [NONCE_W-1:0] nonce,
                                input logic [NOW_W-1:0] stamp,
                                input logic ok,
                                output t_judgement res);
        logic                 newer;
        logic [NONCE_W-1:0]   span;
        res.verdict = VERDICT_REJECT;
        res.age     = '0;
        // direction parity must match the stored nonce, otherwise no state change
        if (nonce[0] != win_newest[0]) begin
            return;
        end
        newer   = nonce > win_newest;
        span    = newer ? (nonce - win_newest) >> 1 : (win_newest - nonce) >> 1;
        res.age = newer ? -span : span;
        if (newer) begin
            res.verdict = VERDICT_ACCEPT;
            if (ok) begin
                // a jump of a whole window or more forgets everything seen
                if (span >= NONCE_W'(WIN_SIZE)) begin
                    win_seen = '0;
                end else begin
                    win_seen = win_seen << span;
                end
                // previous newest still falls in the window up to exactly its size
                if (span <= NONCE_W'(WIN_SIZE)) begin
                    win_seen = win_seen | (WIN_SIZE'(1) << (span - 1));
                end
                win_newest   = nonce;
                win_deadline = DEADLINE_W'(stamp) + DEADLINE_W'(cfg_reorder_time);
            end
        end else if (win_deadline <= DEADLINE_W'(stamp) || span > NONCE_W'(WIN_SIZE)) begin
            res.verdict = VERDICT_REJECT;
        end else if (span == 0 || win_seen[span-1]) begin
            res.verdict = VERDICT_DUP;
        end else begin
            res.verdict = VERDICT_REORDER;
            if (ok) begin
                win_seen = win_seen | (WIN_SIZE'(1) << (span - 1));
            end
        end
    endtask

    function automatic t_stim_row packet_row(input logic [NONCE_W-1:0] nonce,
                                             input logic [NOW_W-1:0] stamp,
                                             input logic ok);
        t_stim_row row;
        row           = '0;
        row.kind      = ROW_PACKET;
        row.nonce     = nonce;
        row.stamp     = stamp;
        row.ok        = ok;
        return row;
    endfunction

    function automatic t_stim_row checked_row(input logic [NONCE_W-1:0] nonce,
                                              input logic [NOW_W-1:0] stamp,
                                              input logic ok,
                                              input t_verdict verdict,
                                              input logic [NONCE_W-1:0] age);
        t_stim_row row;
        row         = packet_row(nonce, stamp, ok);
        row.typed   = 1'b1;
        row.verdict = verdict;
        row.age     = age;
        return row;
    endfunction

    function automatic t_stim_row write_row(input t_cfg_reg idx,
                                            input logic [CFG_DW-1:0] data);
        t_stim_row row;
        row           = '0;
        row.kind      = ROW_REG_WRITE;
        row.reg_index = idx;
        row.reg_data  = data;
        return row;
    endfunction

    task automatic wait_for_results();
        while (pending_verdicts.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // registers only change with nothing in flight
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DW-1:0] data);
        @(negedge clk);
        in_valid <= 1'b0;
        wait_for_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        apply_reg(idx, data);
    endtask

    // offer one packet, hold it until taken, then queue what it should give
    task automatic send_packet(input logic [NONCE_W-1:0] nonce,
                               input logic [NOW_W-1:0] stamp,
                               input logic ok,
                               input logic typed,
                               input t_verdict verdict,
                               input logic [NONCE_W-1:0] age);
        int          gap;
        t_judgement  res;
        gap = in_burst ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        rx_nonce  <= nonce;
        now_stamp <= stamp;
        auth_ok   <= ok;
        do begin
            @(posedge clk);
        end while (!o_in_ready);
        judge_packet(nonce, stamp, ok, res);
        // hand-typed rows override the model's answer
        if (typed) begin
            res.verdict = verdict;
            res.age     = age;
        end
        pending_verdicts.push_back(res);
    endtask

    // result side back-pressure, off during the burst phase
    always @(negedge clk) begin
        if (ready_hold == 0) begin
            ready_hold = in_burst ? 0 : pick_gap();
        end
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // compare each result item with the oldest prediction
    always @(posedge clk) begin
        t_judgement want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("result with no item outstanding: verdict %0d age %0d",
                       o_verdict, o_age);
                mismatch_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_verdict !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, o_verdict);
                    mismatch_count++;
                end
                if (o_age !== want.age) begin
                    $error("age: expected %0d, got %0d", $signed(want.age), o_age);
                    mismatch_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_stim_row          row;
        logic [NONCE_W-1:0] nonce;
        logic [NOW_W-1:0]   stamp;
        logic [RT_W-1:0]    rt;
        logic               mode;
        logic               ok;
        int                 r;
        int                 off;

        cfg_initiator    = 1'b0;
        cfg_reorder_time = REORDER_TIME_RST;
        restart_window();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // responder after reset: stored nonce 1, deadline zero
        corner_rows.push_back(checked_row(0, 0, 1, VERDICT_REJECT, 0));      // parity
        corner_rows.push_back(checked_row(1, 0, 1, VERDICT_REJECT, 0));      // deadline 0
        corner_rows.push_back(checked_row(3, 100, 0, VERDICT_ACCEPT, AGE_MINUS_ONE));
        corner_rows.push_back(checked_row(3, 100, 1, VERDICT_ACCEPT, AGE_MINUS_ONE));
        corner_rows.push_back(checked_row(1, 200, 1, VERDICT_DUP, 1));
        corner_rows.push_back(checked_row(3, 200, 1, VERDICT_DUP, 0));       // age zero
        // jump of exactly one window: bitmap cleared, old newest at the top bit
        corner_rows.push_back(checked_row(131, 300, 1, VERDICT_ACCEPT, -NONCE_W'(64)));
        corner_rows.push_back(checked_row(3, 300, 1, VERDICT_DUP, 64));
        corner_rows.push_back(checked_row(1, 300, 1, VERDICT_REJECT, 65));   // too old
        corner_rows.push_back(checked_row(5, 300, 0, VERDICT_REORDER, 63));  // no mark
        corner_rows.push_back(checked_row(5, 300, 1, VERDICT_REORDER, 63));
        corner_rows.push_back(checked_row(5, 300, 1, VERDICT_DUP, 63));
        corner_rows.push_back(checked_row(7, 10300, 1, VERDICT_REJECT, 62)); // deadline hit
        corner_rows.push_back(packet_row({NONCE_W{1'b1}}, NOW_MAX, 1));      // far jump
        corner_rows.push_back(checked_row(1, NOW_MAX, 1, VERDICT_REJECT,
                                          48'h7FFF_FFFF_FFFF));
        corner_rows.push_back(checked_row(48'hFFFF_FFFF_FFFE, NOW_MAX, 1,
                                          VERDICT_REJECT, 0));
        // initiator: stored nonce 0, upper data bits ignored
        corner_rows.push_back(write_row(CFG_INITIATOR_MODE, 32'hFFFF_FFFF));
        corner_rows.push_back(checked_row(1, 0, 1, VERDICT_REJECT, 0));
        corner_rows.push_back(checked_row(0, 0, 1, VERDICT_REJECT, 0));
        corner_rows.push_back(write_row(CFG_REORDER_TIME, 32'hFFFF_FFFF));
        corner_rows.push_back(checked_row(2, NOW_MAX, 1, VERDICT_ACCEPT, AGE_MINUS_ONE));
        corner_rows.push_back(checked_row(0, NOW_MAX, 1, VERDICT_DUP, 1));
        corner_rows.push_back(write_row(CFG_REORDER_TIME, 32'h0));
        corner_rows.push_back(checked_row(4, 5, 1, VERDICT_ACCEPT, AGE_MINUS_ONE));
        corner_rows.push_back(checked_row(2, 5, 1, VERDICT_REJECT, 1));

        foreach (corner_rows[i]) begin
            row = corner_rows[i];
            if (row.kind == ROW_REG_WRITE) begin
                write_reg(row.reg_index, row.reg_data);
            end else begin
                send_packet(row.nonce, row.stamp, row.ok, row.typed, row.verdict, row.age);
            end
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            // each phase gets its own mode and reorder time, extremes included
            case (phase)
                0: begin mode = 1'b0; rt = REORDER_TIME_RST; end
                1: begin mode = 1'b1; rt = '0; end
                2: begin mode = 1'b0; rt = {RT_W{1'b1}}; end
                3: begin mode = 1'b1; rt = $urandom_range(200, 3000); end
                4: begin mode = 1'b0; rt = $urandom; end
                5: begin mode = 1'b1; rt = REORDER_TIME_RST; end
                default: begin
                    mode = 1'($urandom_range(0, 1));
                    rt   = $urandom_range(0, 600);
                end
            endcase
            write_reg(CFG_REORDER_TIME, rt);
            write_reg(CFG_INITIATOR_MODE, {(CFG_DW-1)'($urandom), mode});
            in_burst = (phase == 5);
            stamp    = NOW_W'($urandom_range(0, 1000));

            for (int n = 0; n < PHASE_PACKETS; n++) begin
                // time mostly creeps forward, sometimes leaps, now and then anywhere
                r = $urandom_range(0, 99);
                if (r < 85) begin
                    stamp = stamp + NOW_W'($urandom_range(0, 400));
                end else if (r < 95) begin
                    stamp = stamp + NOW_W'($urandom_range(0, 30000));
                end else begin
                    stamp = NOW_W'({$urandom, $urandom});
                end

                // nonces mostly around the newest one, with matching parity
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    off   = int'($urandom_range(0, 140)) - 72;
                    nonce = win_newest + NONCE_W'(2 * off);
                end else if (r < 72) begin
                    nonce = win_newest + NONCE_W'(2 * $urandom_range(1, 4));
                end else if (r < 80) begin
                    nonce = win_newest + NONCE_W'(2 * $urandom_range(62, 66));
                end else if (r < 88) begin
                    off   = int'($urandom_range(0, 40)) - 20;
                    nonce = (win_newest + NONCE_W'(2 * off)) ^ NONCE_W'(1);
                end else begin
                    nonce = NONCE_W'({$urandom, $urandom});
                end

                ok = ($urandom_range(0, 99) < 85);
                send_packet(nonce, stamp, ok, 1'b0, VERDICT_REJECT, '0);
            end
            in_burst = 1'b0;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire
